/* design/pdbe_pkg.sv */
// Shared types and constants for the prefix delta block encoder.
// Used by pdbe_ctrl, pdbe_dp and prefix_delta_block_encoder; no dependencies.
package pdbe_pkg;

    localparam int MAX_KEY_LEN  = 24;
    localparam int MAX_RESTARTS = 8;
    localparam int KEY_IDX_W    = $clog2(MAX_KEY_LEN + 1);
    localparam int RST_IDX_W    = $clog2(MAX_RESTARTS);
    localparam int RST_CNT_W    = $clog2(MAX_RESTARTS + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_KEYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_DELTA      = 2'd2;

    localparam logic [1:0] CMD_KEY    = 2'd0;
    localparam logic [1:0] CMD_VALUE  = 2'd1;
    localparam logic [1:0] CMD_DVALUE = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_KEY_LEN = 2'd1;
    localparam logic [1:0] ERR_RST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] value_length;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] error;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHARED,
        S_SUFLEN,
        S_VLEN,
        S_SUFFIX,
        S_FINWORD,
        S_FINCNT
    } t_state;

    typedef enum logic [2:0] {
        SRC_DATA,
        SRC_SHARED,
        SRC_SUFLEN,
        SRC_VLEN,
        SRC_SUFFIX,
        SRC_WORD,
        SRC_COUNT
    } t_src;

    typedef struct packed {
        logic accept;
        logic emit;
        t_src sel;
        logic last;
        logic finalize;
        logic fin_start;
        logic clear;
    } t_ctl;

    typedef struct packed {
        logic       out_ready;
        logic [1:0] in_cmd;
        logic       in_last;
        logic       value_pass;
        logic       value_delta;
        logic       suffix_empty;
        logic       suffix_last;
        logic       vlen_last;
        logic       bidx_last;
        logic       widx_last;
    } t_sts;

endpackage

/* design/pdbe_ctrl.sv */
// Sequencing state machine of the prefix delta block encoder.
// Depends on pdbe_pkg; drives pdbe_dp through t_ctl and reads t_sts.
module pdbe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  pdbe_pkg::t_sts  i_sts,
    output logic            o_in_stall,
    output pdbe_pkg::t_ctl  o_ctl
);

    pdbe_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdbe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pdbe_pkg::S_IDLE: begin
                if (i_in_valid && i_sts.out_ready) begin
                    if (i_sts.in_cmd == pdbe_pkg::CMD_KEY && i_sts.in_last) begin
                        n_state = pdbe_pkg::S_SHARED;
                    end else if (i_sts.in_cmd == pdbe_pkg::CMD_FINISH) begin
                        n_state = pdbe_pkg::S_FINWORD;
                    end
                end
            end
            pdbe_pkg::S_SHARED: begin
                if (i_sts.out_ready) n_state = pdbe_pkg::S_SUFLEN;
            end
            pdbe_pkg::S_SUFLEN: begin
                if (i_sts.out_ready) begin
                    if (!i_sts.value_delta) begin
                        n_state = pdbe_pkg::S_VLEN;
                    end else if (i_sts.suffix_empty) begin
                        n_state = pdbe_pkg::S_IDLE;
                    end else begin
                        n_state = pdbe_pkg::S_SUFFIX;
                    end
                end
            end
            pdbe_pkg::S_VLEN: begin
                if (i_sts.out_ready && i_sts.vlen_last) begin
                    n_state = i_sts.suffix_empty ? pdbe_pkg::S_IDLE : pdbe_pkg::S_SUFFIX;
                end
            end
            pdbe_pkg::S_SUFFIX: begin
                if (i_sts.out_ready && i_sts.suffix_last) n_state = pdbe_pkg::S_IDLE;
            end
            pdbe_pkg::S_FINWORD: begin
                if (i_sts.out_ready && i_sts.bidx_last && i_sts.widx_last) begin
                    n_state = pdbe_pkg::S_FINCNT;
                end
            end
            pdbe_pkg::S_FINCNT: begin
                if (i_sts.out_ready && i_sts.bidx_last) n_state = pdbe_pkg::S_IDLE;
            end
            default: n_state = pdbe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        o_ctl.sel = pdbe_pkg::SRC_DATA;
        o_in_stall = 1'b1;
        case (r_state)
            pdbe_pkg::S_IDLE: begin
                o_in_stall = !i_sts.out_ready;
                if (i_in_valid && i_sts.out_ready) begin
                    o_ctl.accept = 1'b1;
                    if (i_sts.in_cmd == pdbe_pkg::CMD_FINISH) begin
                        o_ctl.fin_start = 1'b1;
                    end else if (i_sts.in_cmd != pdbe_pkg::CMD_KEY && i_sts.value_pass) begin
                        o_ctl.emit = 1'b1;
                        o_ctl.last = 1'b1;
                    end
                end
            end
            pdbe_pkg::S_SHARED: begin
                o_ctl.sel = pdbe_pkg::SRC_SHARED;
                o_ctl.emit = i_sts.out_ready;
            end
            pdbe_pkg::S_SUFLEN: begin
                o_ctl.sel = pdbe_pkg::SRC_SUFLEN;
                o_ctl.emit = i_sts.out_ready;
                if (i_sts.value_delta && i_sts.suffix_empty) begin
                    o_ctl.last = 1'b1;
                    o_ctl.finalize = i_sts.out_ready;
                end
            end
            pdbe_pkg::S_VLEN: begin
                o_ctl.sel = pdbe_pkg::SRC_VLEN;
                o_ctl.emit = i_sts.out_ready;
                if (i_sts.vlen_last && i_sts.suffix_empty) begin
                    o_ctl.last = 1'b1;
                    o_ctl.finalize = i_sts.out_ready;
                end
            end
            pdbe_pkg::S_SUFFIX: begin
                o_ctl.sel = pdbe_pkg::SRC_SUFFIX;
                o_ctl.emit = i_sts.out_ready;
                if (i_sts.suffix_last) begin
                    o_ctl.last = 1'b1;
                    o_ctl.finalize = i_sts.out_ready;
                end
            end
            pdbe_pkg::S_FINWORD: begin
                o_ctl.sel = pdbe_pkg::SRC_WORD;
                o_ctl.emit = i_sts.out_ready;
            end
            pdbe_pkg::S_FINCNT: begin
                o_ctl.sel = pdbe_pkg::SRC_COUNT;
                o_ctl.emit = i_sts.out_ready;
                if (i_sts.bidx_last) begin
                    o_ctl.last = 1'b1;
                    o_ctl.clear = i_sts.out_ready;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* design/pdbe_dp.sv */
// Datapath of the prefix delta block encoder: key banks, restart offsets,
// counters, configuration registers and the output register. Depends on pdbe_pkg.
module pdbe_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pdbe_pkg::t_in                     i_in_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_we,
    input  logic [pdbe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pdbe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  pdbe_pkg::t_ctl                    i_ctl,
    output pdbe_pkg::t_sts                    o_sts,
    output logic                              o_out_valid,
    output pdbe_pkg::t_out                    o_out_data
);

    localparam int KW = pdbe_pkg::KEY_IDX_W;
    localparam int RW = pdbe_pkg::RST_IDX_W;
    localparam int CW = pdbe_pkg::RST_CNT_W;

    logic [15:0]  r_interval;
    logic         r_delta_keys;
    logic         r_value_delta;

    // Two key banks; r_bank selects the one collecting the current key.
    logic [7:0]   r_key0 [pdbe_pkg::MAX_KEY_LEN];
    logic [7:0]   r_key1 [pdbe_pkg::MAX_KEY_LEN];
    logic         r_bank;
    logic [KW-1:0] r_cur_len;
    logic [KW-1:0] r_prev_len;
    logic [KW-1:0] r_run;
    logic         r_match;
    logic         r_ovf;
    logic [KW-1:0] r_shared;
    logic [KW-1:0] r_cur_shared;
    logic [KW-1:0] r_idx;
    logic [1:0]   r_err;
    logic [31:0]  r_vlen;

    logic [31:0]  r_offsets [pdbe_pkg::MAX_RESTARTS];
    logic [CW-1:0] r_rst_cnt;
    logic [15:0]  r_entry_cnt;
    logic [31:0]  r_byte_ofs;
    logic [1:0]   r_bidx;
    logic [RW-1:0] r_widx;

    logic         r_out_valid;
    pdbe_pkg::t_out r_out;

    logic         out_ready;
    logic         key_acc;
    logic         room;
    logic [7:0]   prev_byte;
    logic [7:0]   suf_byte;
    logic [KW-1:0] n_run;
    logic         restart;
    logic         rst_room;
    logic [KW-1:0] new_shared;
    logic [31:0]  word;
    pdbe_pkg::t_out n_out;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign key_acc   = i_ctl.accept && (i_in_data.cmd == pdbe_pkg::CMD_KEY);
    assign room      = r_cur_len < KW'(pdbe_pkg::MAX_KEY_LEN);
    assign restart   = r_entry_cnt >= r_interval;
    assign rst_room  = r_rst_cnt < CW'(pdbe_pkg::MAX_RESTARTS);

    always_comb begin
        prev_byte = 8'd0;
        suf_byte  = 8'd0;
        if (room) prev_byte = r_bank ? r_key0[r_cur_len] : r_key1[r_cur_len];
        if (r_idx < KW'(pdbe_pkg::MAX_KEY_LEN)) begin
            suf_byte = r_bank ? r_key1[r_idx] : r_key0[r_idx];
        end
    end

    // The shared prefix grows while each new key byte matches the previous key.
    always_comb begin
        n_run = r_run;
        if (room && r_match && (r_cur_len < r_prev_len) && (prev_byte == i_in_data.data_byte)) begin
            n_run = r_run + 1'b1;
        end
        new_shared = (restart || !r_delta_keys) ? '0 : n_run;
    end

    always_comb begin
        case (r_bidx)
            2'd0:    word = {24'd0, r_offsets[r_widx][7:0]};
            2'd1:    word = {24'd0, r_offsets[r_widx][15:8]};
            2'd2:    word = {24'd0, r_offsets[r_widx][23:16]};
            default: word = {24'd0, r_offsets[r_widx][31:24]};
        endcase
    end

    always_comb begin
        n_out.out_last = i_ctl.last;
        n_out.error    = r_err;
        case (i_ctl.sel)
            pdbe_pkg::SRC_DATA: begin
                n_out.out_byte = i_in_data.data_byte;
                n_out.error    = pdbe_pkg::ERR_OK;
            end
            pdbe_pkg::SRC_SHARED: n_out.out_byte = 8'(r_shared);
            pdbe_pkg::SRC_SUFLEN: n_out.out_byte = 8'(r_cur_len - r_shared);
            pdbe_pkg::SRC_VLEN:   n_out.out_byte = {(r_vlen[31:7] != '0), r_vlen[6:0]};
            pdbe_pkg::SRC_SUFFIX: n_out.out_byte = suf_byte;
            pdbe_pkg::SRC_WORD: begin
                n_out.out_byte = word[7:0];
                n_out.error    = pdbe_pkg::ERR_OK;
            end
            pdbe_pkg::SRC_COUNT: begin
                n_out.out_byte = (r_bidx == 2'd0) ? 8'(r_rst_cnt) : 8'd0;
                n_out.error    = pdbe_pkg::ERR_OK;
            end
            default: n_out.out_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval    <= 16'd16;
            r_delta_keys  <= 1'b1;
            r_value_delta <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pdbe_pkg::CFG_RESTART_INTERVAL: r_interval    <= i_cfg_data;
                pdbe_pkg::CFG_DELTA_KEYS:       r_delta_keys  <= i_cfg_data[0];
                pdbe_pkg::CFG_VALUE_DELTA:      r_value_delta <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_acc && room) begin
            if (r_bank) r_key1[r_cur_len] <= i_in_data.data_byte;
            else        r_key0[r_cur_len] <= i_in_data.data_byte;
        end
        if (key_acc && i_in_data.last_byte) begin
            r_vlen   <= i_in_data.value_length;
            r_shared <= new_shared;
            r_idx    <= new_shared;
            if (r_ovf || !room)            r_err <= pdbe_pkg::ERR_KEY_LEN;
            else if (restart && !rst_room) r_err <= pdbe_pkg::ERR_RST_FULL;
            else                           r_err <= pdbe_pkg::ERR_OK;
        end
        if (i_ctl.emit && i_ctl.sel == pdbe_pkg::SRC_VLEN) r_vlen <= r_vlen >> 7;
        if (i_ctl.emit && i_ctl.sel == pdbe_pkg::SRC_SUFFIX) r_idx <= r_idx + 1'b1;
        if (key_acc && i_in_data.last_byte && restart && rst_room) begin
            r_offsets[r_rst_cnt[RW-1:0]] <= r_byte_ofs;
        end
        if (!i_rst_n || i_ctl.clear) r_offsets[0] <= 32'd0;
        if (i_ctl.emit) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_bank       <= 1'b0;
            r_cur_len    <= '0;
            r_prev_len   <= '0;
            r_run        <= '0;
            r_match      <= 1'b1;
            r_ovf        <= 1'b0;
            r_cur_shared <= '0;
            r_rst_cnt    <= CW'(1);
            r_entry_cnt  <= 16'd0;
            r_byte_ofs   <= 32'd0;
            r_bidx       <= 2'd0;
            r_widx       <= '0;
        end else begin
            if (key_acc) begin
                if (room) begin
                    r_cur_len <= r_cur_len + 1'b1;
                    r_run     <= n_run;
                    if (n_run == r_run) r_match <= 1'b0;
                end else begin
                    r_ovf <= 1'b1;
                end
                if (i_in_data.last_byte) begin
                    if (restart) begin
                        r_entry_cnt <= 16'd1;
                        if (rst_room) r_rst_cnt <= r_rst_cnt + 1'b1;
                    end else begin
                        r_entry_cnt <= r_entry_cnt + 16'd1;
                    end
                end
            end
            if (i_ctl.finalize) begin
                if (r_delta_keys) begin
                    r_bank     <= !r_bank;
                    r_prev_len <= r_cur_len;
                end
                r_cur_shared <= r_shared;
                r_cur_len    <= '0;
                r_run        <= '0;
                r_match      <= 1'b1;
                r_ovf        <= 1'b0;
            end
            if (i_ctl.fin_start) begin
                // A partial key is thrown away by the clear at the end of the finish.
                r_bidx <= 2'd0;
                r_widx <= '0;
            end
            if (i_ctl.emit) begin
                r_byte_ofs <= r_byte_ofs + 32'd1;
                if (i_ctl.sel == pdbe_pkg::SRC_WORD || i_ctl.sel == pdbe_pkg::SRC_COUNT) begin
                    r_bidx <= r_bidx + 2'd1;
                end
                if (i_ctl.sel == pdbe_pkg::SRC_WORD && r_bidx == 2'd3) begin
                    r_widx <= r_widx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.out_ready    = out_ready;
        o_sts.in_cmd       = i_in_data.cmd;
        o_sts.in_last      = i_in_data.last_byte;
        o_sts.value_pass   = (i_in_data.cmd == pdbe_pkg::CMD_DVALUE)
                             == ((r_cur_shared != '0) && r_value_delta);
        o_sts.value_delta  = r_value_delta;
        o_sts.suffix_empty = r_cur_len == r_shared;
        o_sts.suffix_last  = (r_idx + 1'b1) == r_cur_len;
        o_sts.vlen_last    = r_vlen[31:7] == '0;
        o_sts.bidx_last    = r_bidx == 2'd3;
        o_sts.widx_last    = (CW'(r_widx) + CW'(1)) == r_rst_cnt;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* design/prefix_delta_block_encoder.sv */
// Top level of the prefix delta block encoder.
// Depends on pdbe_pkg, pdbe_ctrl and pdbe_dp.
//
// Each request on the input channel carries one key byte, value byte, delta
// value byte or a finish command. Key bytes are taken one per cycle while the
// output slot can accept, and give no output until the last key byte; that
// byte starts a burst of shared length, suffix length, optional value length
// varint (one to five bytes) and the key suffix, during which the input is
// stalled; the burst gives one output request per cycle while the output is
// not stalled. A passed value byte is loaded straight into the output
// register when it is taken. A finish emits four bytes per restart offset
// and four bytes of count, then clears the block.
// The output register decouples the sides: while the receiver stalls, the
// sequencer holds its place and the input is stalled whenever the output
// slot is occupied and cannot drain. Reset is synchronous and restores the
// register defaults and an empty block; no clearing pass is needed.
// A key longer than the store or a full restart store is flagged on every
// output byte of that entry through the error field.
module prefix_delta_block_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pdbe_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pdbe_pkg::t_out                   o_out_data,
    input  logic                             i_cfg_we,
    input  logic [pdbe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pdbe_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pdbe_pkg::t_ctl ctl;
    pdbe_pkg::t_sts sts;

    pdbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_ctl      (ctl)
    );

    pdbe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
